FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// checked while reset is low
`define ASSERT_RUN(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define ASSERT_RUN(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

FILE: rtl/iasmd_pkg.sv
// ----------------------------------------------------------------------------
// iasmd_pkg
// shared types and constants of the integer add/sub/mul/div unit
// ----------------------------------------------------------------------------
package iasmd_pkg;

   localparam int WORD_BITS_DEFAULT = 32;

   typedef enum logic [1:0] {
      ACT_ADD = 2'd0,
      ACT_SUB = 2'd1,
      ACT_MUL = 2'd2,
      ACT_DIV = 2'd3
   } action_type;

   typedef struct packed {
      logic load;
      logic step;
      logic store;
   } dp_cmd_type;

endpackage

FILE: rtl/iasmd_ctrl.sv
// ----------------------------------------------------------------------------
// iasmd_ctrl
// sequencer: takes an item, runs the bit steps of mul and div, hands the result to the output
// ----------------------------------------------------------------------------
module iasmd_ctrl
   import iasmd_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  action_type action,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output dp_cmd_type cmd
);

   localparam int CNT_BITS = $clog2(WORD_BITS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               cnt_in   = CNT_BITS'(WORD_BITS - 1);
               if (action == ACT_MUL || action == ACT_DIV) begin
                  state_in = ST_STEP;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.store    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/iasmd_dp.sv
// ----------------------------------------------------------------------------
// iasmd_dp
// operand registers, shift-add / restoring step unit and result register
// ----------------------------------------------------------------------------
module iasmd_dp
   import iasmd_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic                 clock,
   input  dp_cmd_type           cmd,
   input  action_type           action,
   input  logic [WORD_BITS-1:0] lhs,
   input  logic [WORD_BITS-1:0] rhs,
   output logic [WORD_BITS-1:0] value,
   output logic                 divide_by_zero
);

   localparam int W = WORD_BITS;

   action_type     op_ff, op_in;
   logic [W-1:0]   x_ff, x_in;
   logic [W-1:0]   y_ff, y_in;
   logic [W-1:0]   acc_ff, acc_in;
   logic           neg_ff, neg_in;
   logic           dz_ff, dz_in;
   logic [W-1:0]   value_ff, value_in;
   logic           dzo_ff, dzo_in;

   logic [W-1:0]   lhs_mag, rhs_mag;
   logic [W:0]     rem_shift;
   logic [W+1:0]   rem_diff;

   assign lhs_mag   = lhs[W-1] ? W'(~lhs + 1'b1) : lhs;
   assign rhs_mag   = rhs[W-1] ? W'(~rhs + 1'b1) : rhs;
   assign rem_shift = {acc_ff, y_ff[W-1]};
   assign rem_diff  = {1'b0, rem_shift} - {2'b00, x_ff};

   always_comb begin
      op_in    = op_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      dz_in    = dz_ff;
      value_in = value_ff;
      dzo_in   = dzo_ff;
      if (cmd.load) begin
         op_in  = action;
         acc_in = '0;
         neg_in = lhs[W-1] ^ rhs[W-1];
         dz_in  = (action == ACT_DIV) && (rhs == '0);
         if (action == ACT_DIV) begin
            x_in = rhs_mag;
            y_in = lhs_mag;
         end else begin
            x_in = lhs;
            y_in = rhs;
         end
      end
      if (cmd.step) begin
         if (op_ff == ACT_MUL) begin
            acc_in = y_ff[0] ? acc_ff + x_ff : acc_ff;
            x_in   = {x_ff[W-2:0], 1'b0};
            y_in   = {1'b0, y_ff[W-1:1]};
         end else begin
            if (!rem_diff[W+1]) begin
               acc_in = rem_diff[W-1:0];
               y_in   = {y_ff[W-2:0], 1'b1};
            end else begin
               acc_in = rem_shift[W-1:0];
               y_in   = {y_ff[W-2:0], 1'b0};
            end
         end
      end
      if (cmd.store) begin
         dzo_in = dz_ff;
         unique case (op_ff)
            ACT_ADD: value_in = x_ff + y_ff;
            ACT_SUB: value_in = x_ff - y_ff;
            ACT_MUL: value_in = acc_ff;
            ACT_DIV: begin
               if (dz_ff) begin
                  value_in = '0;
               end else begin
                  value_in = neg_ff ? W'(~y_ff + 1'b1) : y_ff;
               end
            end
            default: value_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      acc_ff   <= acc_in;
      neg_ff   <= neg_in;
      dz_ff    <= dz_in;
      value_ff <= value_in;
      dzo_ff   <= dzo_in;
   end

   assign value          = value_ff;
   assign divide_by_zero = dzo_ff;

endmodule

FILE: rtl/integer_add_sub_mul_div_unit.sv
// ----------------------------------------------------------------------------
// integer_add_sub_mul_div_unit
// two's complement add, subtract, shift-add multiply and restoring divide
// ----------------------------------------------------------------------------
// usage:
//   req channel carries one item: req_tuser is the operation (add, sub, mul,
//   div), req_tdata holds lhs in the low word and rhs in the next word.
//   rsp channel returns one item per request: rsp_tdata is the wrapped
//   result, rsp_tuser flags a divide by zero (result then reads zero).
// sequencing:
//   add and subtract go from accept straight to the result store; multiply
//   and divide first run one multiplier or quotient bit per cycle through
//   the shared step unit.
//   req_tready is high only while the sequencer is idle, so one item is in
//   work at a time; a new item is taken while the previous result waits.
// reset:
//   synchronous, active high; clears the sequencer and rsp_tvalid.
// stall:
//   a held result stays in the output register until rsp_tready; the next
//   finished result waits in the sequencer and no further item is taken.
// ----------------------------------------------------------------------------
module integer_add_sub_mul_div_unit
   import iasmd_pkg::*;
#(
   parameter  int WORD_BITS     = WORD_BITS_DEFAULT,
   localparam int IN_DATA_BITS  = ((2 * WORD_BITS + 7) / 8) * 8,
   localparam int OUT_DATA_BITS = ((WORD_BITS + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [IN_DATA_BITS-1:0]  req_tdata,   // lhs, rhs
   input  logic [1:0]               req_tuser,   // action
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [OUT_DATA_BITS-1:0] rsp_tdata,   // value
   output logic                     rsp_tuser    // divide_by_zero
);

`include "assert_macros.svh"

   dp_cmd_type           cmd;
   action_type           action;
   logic [WORD_BITS-1:0] lhs, rhs, value;

   assign action    = action_type'(req_tuser);
   assign lhs       = req_tdata[WORD_BITS-1:0];
   assign rhs       = req_tdata[2*WORD_BITS-1:WORD_BITS];
   assign rsp_tdata = OUT_DATA_BITS'(value);

   iasmd_ctrl #(
      .WORD_BITS (WORD_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .action     (action),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   iasmd_dp #(
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock          (clock),
      .cmd            (cmd),
      .action         (action),
      .lhs            (lhs),
      .rhs            (rhs),
      .value          (value),
      .divide_by_zero (rsp_tuser)
   );

   `ASSERT_RUN(a_cmd_onehot, clock, reset, $onehot0(cmd))
   `ASSERT_RUN(a_busy_after_accept, clock, reset, req_tvalid && req_tready |=> !req_tready)
   `ASSERT_RUN(a_dz_zero, clock, reset, rsp_tvalid && rsp_tuser |-> value == '0)
   `ASSERT_ALWAYS(a_reset_no_rsp, clock, $past(reset) |-> !rsp_tvalid)

endmodule

FILE: test/iasmd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iasmd_checker
// watches the req and rsp channels of the add/sub/mul/div unit, works out the
// expected result of every accepted req item and checks each rsp item against
// the oldest one still due
// ----------------------------------------------------------------------------
module iasmd_checker
   import iasmd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,   // lhs, rhs
   input  logic [1:0]  req_tuser,   // action
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // value
   input  logic        rsp_tuser,   // divide_by_zero
   output int          mismatch_count,
   output int          results_outstanding
);

   typedef struct packed {
      logic [31:0] value;
      logic        divide_by_zero;
   } arith_result_type;

   arith_result_type results_due[$];

   function automatic logic [31:0] magnitude(input logic [31:0] x);
      return x[31] ? ~x + 32'd1 : x;
   endfunction

   function automatic arith_result_type arith_result(input action_type act,
                                                     input logic [31:0] lhs,
                                                     input logic [31:0] rhs);
      arith_result_type r;
      logic [31:0]      acc;
      logic [31:0]      multiplicand;
      logic [31:0]      multiplier;
      logic [31:0]      dividend;
      logic [31:0]      divisor;
      logic [31:0]      quotient;
      logic [32:0]      partial;
      r.value          = '0;
      r.divide_by_zero = 1'b0;
      case (act)
         ACT_ADD: r.value = lhs + rhs;
         ACT_SUB: r.value = lhs + (~rhs + 32'd1);
         ACT_MUL: begin
            acc          = '0;
            multiplicand = lhs;
            multiplier   = rhs;
            for (int i = 0; i < 32; i++) begin
               if (multiplier[0]) begin
                  acc = acc + multiplicand;
               end
               multiplicand = multiplicand << 1;
               multiplier   = multiplier >> 1;
            end
            r.value = acc;
         end
         ACT_DIV: begin
            if (rhs == '0) begin
               r.divide_by_zero = 1'b1;
            end else begin
               dividend = magnitude(lhs);
               divisor  = magnitude(rhs);
               partial  = '0;
               quotient = '0;
               for (int i = 31; i >= 0; i--) begin
                  partial = {partial[31:0], dividend[i]};
                  if (partial >= {1'b0, divisor}) begin
                     partial     = partial - {1'b0, divisor};
                     quotient[i] = 1'b1;
                  end
               end
               r.value = (lhs[31] != rhs[31]) ? ~quotient + 32'd1 : quotient;
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      arith_result_type due;
      int               errors;
      errors = 0;
      if (reset) begin
         results_due.delete();
      end else begin
         // an rsp item at this edge always belongs to an earlier req item
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               $error("rsp item with no result due: value %h divide_by_zero %b",
                      rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               due = results_due.pop_front();
               if (rsp_tdata !== due.value) begin
                  $error("value mismatch: expected %h actual %h", due.value, rsp_tdata);
                  errors++;
               end
               if (rsp_tuser !== due.divide_by_zero) begin
                  $error("divide_by_zero mismatch: expected %b actual %b",
                         due.divide_by_zero, rsp_tuser);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            results_due.push_back(arith_result(action_type'(req_tuser),
                                               req_tdata[31:0], req_tdata[63:32]));
         end
      end
      mismatch_count      <= mismatch_count + errors;
      results_outstanding <= results_due.size();
   end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives directed corner cases and random operations into the add/sub/mul/div
// unit with random gaps on req and random stalls on rsp; a checker beside the
// unit predicts and compares every result
// ----------------------------------------------------------------------------
module tb;
   import iasmd_pkg::*;

   localparam int          RANDOM_ITEMS = 1700;
   localparam int          CYCLE_LIMIT  = 600000;
   localparam int          DRAIN_CYCLES = 40;
   localparam logic [31:0] MOST_POS     = 32'h7fff_ffff;
   localparam logic [31:0] MOST_NEG     = 32'h8000_0000;
   localparam logic [31:0] ALL_ONES     = 32'hffff_ffff;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   int          mismatch_count;
   int          results_outstanding;
   int          cycle_count;
   bit          req_quiet;
   bit          rsp_quiet;

   integer_add_sub_mul_div_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   iasmd_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_tvalid          (req_tvalid),
      .req_tready          (req_tready),
      .req_tdata           (req_tdata),
      .req_tuser           (req_tuser),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_tdata           (rsp_tdata),
      .rsp_tuser           (rsp_tuser),
      .mismatch_count      (mismatch_count),
      .results_outstanding (results_outstanding)
   );

   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
   end

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // starts and ends at a falling edge
   task automatic send_item(input action_type act, input logic [31:0] lhs,
                            input logic [31:0] rhs);
      int gap;
      if ($urandom_range(0, 15) == 0) begin
         req_quiet = !req_quiet;
      end
      gap = req_quiet ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {rhs, lhs};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      @(negedge clock);
   endtask

   function automatic logic [31:0] draw_operand();
      logic [31:0] x;
      case ($urandom_range(0, 5))
         0: x = $urandom_range(0, 32) - 16;
         1: begin
            case ($urandom_range(0, 5))
               0:       x = '0;
               1:       x = 32'd1;
               2:       x = ALL_ONES;
               3:       x = MOST_POS;
               4:       x = MOST_NEG;
               default: x = MOST_NEG + 32'd1;
            endcase
         end
         2: begin
            x = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1) == 1) begin
               x = ~x + 32'd1;
            end
         end
         default: x = $urandom;
      endcase
      return x;
   endfunction

   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) begin
            rsp_quiet = !rsp_quiet;
         end
         if (!rsp_quiet) begin
            int stall;
            stall = $urandom_range(0, 16);
            if (stall != 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wrap at the extremes
      send_item(ACT_ADD, MOST_POS, 32'd1);
      send_item(ACT_ADD, MOST_NEG, ALL_ONES);
      send_item(ACT_ADD, '0, '0);
      send_item(ACT_ADD, ALL_ONES, ALL_ONES);
      send_item(ACT_SUB, MOST_NEG, 32'd1);
      send_item(ACT_SUB, MOST_POS, ALL_ONES);
      send_item(ACT_SUB, '0, MOST_NEG);
      send_item(ACT_MUL, MOST_POS, MOST_POS);
      send_item(ACT_MUL, MOST_NEG, ALL_ONES);
      send_item(ACT_MUL, ALL_ONES, ALL_ONES);
      send_item(ACT_MUL, 32'h1234_5678, '0);
      send_item(ACT_MUL, ALL_ONES, MOST_POS);
      // divide by zero, most negative dividend and divisor, signs
      send_item(ACT_DIV, 32'd7, '0);
      send_item(ACT_DIV, MOST_NEG, '0);
      send_item(ACT_DIV, MOST_NEG, ALL_ONES);
      send_item(ACT_DIV, MOST_NEG, MOST_NEG);
      send_item(ACT_DIV, 32'd5, MOST_NEG);
      send_item(ACT_DIV, MOST_POS, MOST_NEG);
      send_item(ACT_DIV, -32'sd7, 32'd2);
      send_item(ACT_DIV, 32'd7, -32'sd2);
      send_item(ACT_DIV, -32'sd7, -32'sd2);
      send_item(ACT_DIV, '0, 32'd5);
      send_item(ACT_DIV, MOST_POS, 32'd1);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         send_item(action_type'($urandom_range(0, 3)), draw_operand(), draw_operand());
      end
      req_tvalid <= 1'b0;

      while (results_outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && results_outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/iasmd_pkg.sv
rtl/iasmd_ctrl.sv
rtl/iasmd_dp.sv
rtl/integer_add_sub_mul_div_unit.sv
test/iasmd_checker.sv
test/tb.sv
